@@ rtl/core/usfr_pkg.sv @@
// Shared types, service codes and DID table for the UDS single-frame responder.
`timescale 1ns / 1ps

package usfr_pkg;

	localparam int unsigned IdW    = 29;
	localparam int unsigned DlcW   = 4;
	localparam int unsigned DataW  = 64;
	localparam int unsigned CfgIdxW = 2;

	localparam logic [CfgIdxW-1:0] CfgAdapterOpen = 2'd0;
	localparam logic [CfgIdxW-1:0] CfgEcuEnable   = 2'd1;
	localparam logic [CfgIdxW-1:0] CfgRequestId   = 2'd2;
	localparam logic [CfgIdxW-1:0] CfgResponseId  = 2'd3;

	localparam logic [IdW-1:0] RequestIdRst  = 29'h7E0;
	localparam logic [IdW-1:0] ResponseIdRst = 29'h7E8;
	localparam logic [7:0]     SessionRst    = 8'h01;
	localparam logic [DlcW-1:0] DlcMax       = 4'd8;

	localparam logic [7:0] SidSession    = 8'h10;
	localparam logic [7:0] SidEcuReset   = 8'h11;
	localparam logic [7:0] SidReadDid    = 8'h22;
	localparam logic [7:0] SidWriteDid   = 8'h2E;
	localparam logic [7:0] SidRoutine    = 8'h31;
	localparam logic [7:0] SidTesterPres = 8'h3E;

	localparam logic [7:0] RspSession    = 8'h50;
	localparam logic [7:0] RspEcuReset   = 8'h51;
	localparam logic [7:0] RspReadDid    = 8'h62;
	localparam logic [7:0] RspWriteDid   = 8'h6E;
	localparam logic [7:0] RspRoutine    = 8'h71;
	localparam logic [7:0] RspTesterPres = 8'h7E;
	localparam logic [7:0] RspNegative   = 8'h7F;
	localparam logic [7:0] NrcNotSupp    = 8'h11;

	localparam logic [15:0] DidVin    = 16'hF190;
	localparam logic [15:0] DidHw     = 16'hF18E;
	localparam logic [15:0] DidSw     = 16'hF18A;
	localparam logic [15:0] DidVendor = 16'hF18C;
	localparam logic [15:0] DidCustom = 16'h1234;

	typedef enum logic [2:0] {
		KIND_NONE,
		KIND_SESSION,
		KIND_READ_DID,
		KIND_WRITE_DID,
		KIND_ROUTINE,
		KIND_TESTER_PRES,
		KIND_ECU_RESET,
		KIND_NEGATIVE
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] sid;
		logic [7:0] b2;
		logic [7:0] b3;
		logic [7:0] b4;
	} req_t;

	typedef struct packed {
		logic [DlcW-1:0]  len;
		logic [DataW-1:0] data;
	} rsp_t;

	// Read DID reply frame; long records give the first-frame header and six bytes.
	function automatic rsp_t did_reply(input logic [15:0] did);
		rsp_t r;
		r.len = 4'd8;
		unique case (did)
			DidVin:    r.data = {"S", "E", "T", did[7:0], did[15:8], RspReadDid, 8'd20, 8'h10};
			DidHw:     r.data = {"_", "W", "H", did[7:0], did[15:8], RspReadDid, 8'd12, 8'h10};
			DidSw:     r.data = {"_", "W", "S", did[7:0], did[15:8], RspReadDid, 8'd12, 8'h10};
			DidVendor: r.data = {"R", "I", "V", did[7:0], did[15:8], RspReadDid, 8'd10, 8'h10};
			DidCustom: r.data = {8'h78, 8'h56, 8'h34, 8'h12, did[7:0], did[15:8], RspReadDid,
				8'd7};
			default: begin
				r.len  = 4'd6;
				r.data = {8'h00, 8'h00, 8'h00, 8'h00, did[7:0], did[15:8], RspReadDid, 8'd5};
			end
		endcase
		return r;
	endfunction

endpackage

@@ rtl/core/uds_single_frame_responder.sv @@
// Top level of the UDS single-frame responder: three-stage frame pipeline.
`timescale 1ns / 1ps

// Takes one CAN frame per cycle while frame_stall is low and gives exactly one
// result item per frame once it has passed stages one, two and three. Stage one
// registers the frame with the adapter and identifier checks, stage two checks
// the ISO-TP single-frame header and decodes the service, stage three builds
// the reply, from the DID table for Read DID. Each stage advances when the
// stage after it is empty or moving, so bubbles close up and a stall on the
// reply side backs up to frame_stall. cfg_ready is always high; configuration
// is meant to be written only while no frame is in flight.

module uds_single_frame_responder (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [usfr_pkg::CfgIdxW-1:0]       cfg_index,
	input  logic [usfr_pkg::IdW-1:0]           cfg_data,
	input  logic                               frame_valid,
	output logic                               frame_stall,
	input  logic [usfr_pkg::IdW-1:0]           frame_id,
	input  logic                               frame_extended,
	input  logic [usfr_pkg::DlcW-1:0]          frame_length,
	input  logic [usfr_pkg::DataW-1:0]         frame_payload,
	output logic                               reply_valid,
	input  logic                               reply_stall,
	output logic                               accepted,
	output logic                               responded,
	output logic [usfr_pkg::IdW-1:0]           reply_id,
	output logic                               reply_extended,
	output logic [usfr_pkg::DlcW-1:0]          reply_length,
	output logic [usfr_pkg::DataW-1:0]         reply_payload
);

	logic                        adapter_open_q;
	logic                        ecu_enable_q;
	logic [usfr_pkg::IdW-1:0]    request_id_q;
	logic [usfr_pkg::IdW-1:0]    response_id_q;
	logic [7:0]                  diag_session_q;

	logic                        en1, en2, en3;
	logic                        valid_s1, valid_s2, valid_s3;

	logic                        acc_s1, hit_s1, ext_s1;
	logic [usfr_pkg::DlcW-1:0]   dlc_s1;
	logic [39:0]                 pl_s1;

	logic                        acc_s2, ext_s2;
	usfr_pkg::req_t              req_s2;

	logic                        acc_s3, resp_s3, ext_s3;
	logic [usfr_pkg::IdW-1:0]    id_s3;
	logic [usfr_pkg::DlcW-1:0]   len_s3;
	logic [usfr_pkg::DataW-1:0]  data_s3;

	logic [usfr_pkg::DlcW-1:0]   dlc_clamp;
	logic [3:0]                  sf_len;
	logic                        sf_ok;
	usfr_pkg::req_t              req_d;
	usfr_pkg::rsp_t              rsp_d;

	assign en3         = !valid_s3 || !reply_stall;
	assign en2         = !valid_s2 || en3;
	assign en1         = !valid_s1 || en2;
	assign frame_stall = !en1;
	assign cfg_ready   = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			adapter_open_q <= 1'b0;
			ecu_enable_q   <= 1'b1;
			request_id_q   <= usfr_pkg::RequestIdRst;
			response_id_q  <= usfr_pkg::ResponseIdRst;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				usfr_pkg::CfgAdapterOpen: adapter_open_q <= cfg_data[0];
				usfr_pkg::CfgEcuEnable:   ecu_enable_q   <= cfg_data[0];
				usfr_pkg::CfgRequestId:   request_id_q   <= cfg_data;
				usfr_pkg::CfgResponseId:  response_id_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage one
	assign dlc_clamp = (frame_length > usfr_pkg::DlcMax) ? usfr_pkg::DlcMax : frame_length;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en1) begin
			valid_s1 <= frame_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && frame_valid) begin
			acc_s1 <= adapter_open_q;
			hit_s1 <= adapter_open_q && ecu_enable_q && (frame_id == request_id_q);
			ext_s1 <= frame_extended;
			dlc_s1 <= dlc_clamp;
			pl_s1  <= frame_payload[39:0];
		end
	end

	// Stage two: single-frame header check and service decode
	assign sf_len = pl_s1[3:0];
	assign sf_ok  = hit_s1 && (dlc_s1 != '0) && (pl_s1[7:4] == 4'd0) && (sf_len != 4'd0)
		&& ({1'b0, sf_len} + 5'd1 <= {1'b0, dlc_s1});

	always_comb begin
		req_d.sid  = pl_s1[15:8];
		req_d.b2   = pl_s1[23:16];
		req_d.b3   = pl_s1[31:24];
		req_d.b4   = pl_s1[39:32];
		req_d.kind = usfr_pkg::KIND_NONE;
		if (sf_ok) begin
			unique case (pl_s1[15:8])
				usfr_pkg::SidSession:
					req_d.kind = (sf_len >= 4'd2) ? usfr_pkg::KIND_SESSION : usfr_pkg::KIND_NONE;
				usfr_pkg::SidReadDid:
					req_d.kind = (sf_len >= 4'd3) ? usfr_pkg::KIND_READ_DID : usfr_pkg::KIND_NONE;
				usfr_pkg::SidWriteDid:
					req_d.kind = (sf_len >= 4'd3) ? usfr_pkg::KIND_WRITE_DID : usfr_pkg::KIND_NONE;
				usfr_pkg::SidRoutine:
					req_d.kind = (sf_len >= 4'd4) ? usfr_pkg::KIND_ROUTINE : usfr_pkg::KIND_NONE;
				usfr_pkg::SidTesterPres: req_d.kind = usfr_pkg::KIND_TESTER_PRES;
				usfr_pkg::SidEcuReset:   req_d.kind = usfr_pkg::KIND_ECU_RESET;
				default:                 req_d.kind = usfr_pkg::KIND_NEGATIVE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2       <= 1'b0;
			diag_session_q <= usfr_pkg::SessionRst;
		end else if (en2) begin
			valid_s2 <= valid_s1;
			if (valid_s1 && req_d.kind == usfr_pkg::KIND_SESSION) begin
				diag_session_q <= req_d.b2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && valid_s1) begin
			acc_s2 <= acc_s1;
			ext_s2 <= ext_s1;
			req_s2 <= req_d;
		end
	end

	// Stage three: reply build. The session register was last set by the item
	// now in stage two, so a session reply echoes it directly.
	usfr_reply_gen u_reply_gen (
		.req     (req_s2),
		.session (diag_session_q),
		.rsp     (rsp_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en3 && valid_s2) begin
			acc_s3  <= acc_s2;
			resp_s3 <= (req_s2.kind != usfr_pkg::KIND_NONE);
			id_s3   <= (req_s2.kind != usfr_pkg::KIND_NONE) ? response_id_q : '0;
			ext_s3  <= (req_s2.kind != usfr_pkg::KIND_NONE) && ext_s2;
			len_s3  <= rsp_d.len;
			data_s3 <= rsp_d.data;
		end
	end

	assign reply_valid    = valid_s3;
	assign accepted       = acc_s3;
	assign responded      = resp_s3;
	assign reply_id       = id_s3;
	assign reply_extended = ext_s3;
	assign reply_length   = len_s3;
	assign reply_payload  = data_s3;

endmodule

@@ rtl/core/usfr_reply_gen.sv @@
// Reply frame builder: decoded request to reply length and data bytes.
`timescale 1ns / 1ps

module usfr_reply_gen (
	input  usfr_pkg::req_t req,
	input  logic [7:0]     session,
	output usfr_pkg::rsp_t rsp
);

	always_comb begin
		rsp.len  = '0;
		rsp.data = '0;
		unique case (req.kind)
			usfr_pkg::KIND_NONE: begin
				rsp.len = '0;
			end
			usfr_pkg::KIND_SESSION: begin
				rsp.len  = 4'd3;
				rsp.data = {40'd0, session, usfr_pkg::RspSession, 8'h02};
			end
			usfr_pkg::KIND_READ_DID: begin
				rsp = usfr_pkg::did_reply({req.b2, req.b3});
			end
			usfr_pkg::KIND_WRITE_DID: begin
				rsp.len  = 4'd4;
				rsp.data = {32'd0, req.b3, req.b2, usfr_pkg::RspWriteDid, 8'h03};
			end
			usfr_pkg::KIND_ROUTINE: begin
				rsp.len  = 4'd5;
				rsp.data = {24'd0, req.b4, req.b3, req.b2, usfr_pkg::RspRoutine, 8'h04};
			end
			usfr_pkg::KIND_TESTER_PRES: begin
				rsp.len  = 4'd2;
				rsp.data = {48'd0, usfr_pkg::RspTesterPres, 8'h01};
			end
			usfr_pkg::KIND_ECU_RESET: begin
				rsp.len  = 4'd2;
				rsp.data = {48'd0, usfr_pkg::RspEcuReset, 8'h01};
			end
			usfr_pkg::KIND_NEGATIVE: begin
				rsp.len  = 4'd4;
				rsp.data = {32'd0, usfr_pkg::NrcNotSupp, req.sid, usfr_pkg::RspNegative, 8'h03};
			end
			default: begin
				rsp.len = '0;
			end
		endcase
	end

endmodule

@@ rtl/core/usfr_checker.sv @@
// Port-level assertions for the UDS single-frame responder, bound to the top level.
`timescale 1ns / 1ps

module usfr_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         frame_valid,
	input logic                         frame_stall,
	input logic                         reply_valid,
	input logic                         reply_stall,
	input logic                         accepted,
	input logic                         responded,
	input logic                         reply_extended,
	input logic [usfr_pkg::IdW-1:0]     reply_id,
	input logic [usfr_pkg::DlcW-1:0]    reply_length,
	input logic [usfr_pkg::DataW-1:0]   reply_payload
);

	a_resp_needs_acc: assert property (@(posedge clk) disable iff (!arst_n)
		reply_valid && responded |-> accepted)
		else $error("reply without an accepted frame");

	a_silent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		reply_valid && !responded |-> reply_length == '0 && reply_payload == '0
			&& reply_id == '0 && !reply_extended)
		else $error("non-reply item carries data");

	a_resp_len: assert property (@(posedge clk) disable iff (!arst_n)
		reply_valid && responded |-> reply_length >= 4'd2 && reply_length <= 4'd8)
		else $error("reply length out of range");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		reply_valid && reply_stall |=> reply_valid && $stable(reply_payload)
			&& $stable(reply_length))
		else $error("stalled reply changed");

	a_stall_backs_up: assert property (@(posedge clk) disable iff (!arst_n)
		frame_stall |-> reply_valid && reply_stall)
		else $error("input stalled while output free");

endmodule

bind uds_single_frame_responder usfr_checker u_usfr_checker (.*);

@@ sim/uds_single_frame_responder_tb.sv @@
// Self-checking testbench for the UDS single-frame responder.
`timescale 1ns / 1ps

module uds_single_frame_responder_tb;
	import usfr_pkg::*;

	typedef struct packed {
		logic [IdW-1:0]   id;
		logic             ext;
		logic [DlcW-1:0]  len;
		logic [DataW-1:0] data;
	} frame_t;

	typedef struct packed {
		logic             accepted;
		logic             responded;
		logic [IdW-1:0]   id;
		logic             ext;
		logic [DlcW-1:0]  len;
		logic [DataW-1:0] data;
	} reply_t;

	logic                clk;
	logic                arst_n         = 1'b0;
	logic                cfg_valid      = 1'b0;
	logic                cfg_ready;
	logic [CfgIdxW-1:0]  cfg_index      = '0;
	logic [IdW-1:0]      cfg_data       = '0;
	logic                frame_valid    = 1'b0;
	logic                frame_stall;
	logic [IdW-1:0]      frame_id       = '0;
	logic                frame_extended = 1'b0;
	logic [DlcW-1:0]     frame_length   = '0;
	logic [DataW-1:0]    frame_payload  = '0;
	logic                reply_valid;
	logic                reply_stall    = 1'b0;
	logic                accepted;
	logic                responded;
	logic [IdW-1:0]      reply_id;
	logic                reply_extended;
	logic [DlcW-1:0]     reply_length;
	logic [DataW-1:0]    reply_payload;

	// mirror of the block's registers and session
	logic           open_q    = 1'b0;
	logic           enable_q  = 1'b1;
	logic [IdW-1:0] req_id_q  = RequestIdRst;
	logic [IdW-1:0] resp_id_q = ResponseIdRst;
	logic [7:0]     diag_session = SessionRst;

	reply_t expected_replies [$];
	int     fail_count = 0;
	bit     idle_en    = 1'b1;
	int     frame_calm = 0;
	int     stall_left = 0;
	int     stall_calm = 0;

	uds_single_frame_responder dut (.*);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		#5_000_000;
		$display("Regression FAIL");
		$finish;
	end

	function automatic reply_t predict_reply(input frame_t f);
		reply_t       r;
		logic [3:0]   dlc;
		logic [3:0]   sf_len;
		logic [7:0]   sid;
		logic [15:0]  did;
		logic [7:0]   rsp [0:23];
		logic [63:0]  rp;
		int           rlen;
		int           rec_len;
		int           total;
		string        rec;
		r        = '0;
		r.accepted = open_q;
		rp       = '0;
		rlen     = 0;
		if (!open_q || !enable_q || f.id != req_id_q)
			return r;
		dlc = (f.len > DlcMax) ? DlcMax : f.len;
		if (dlc == 0 || f.data[7:4] != 4'h0)
			return r;
		sf_len = f.data[3:0];
		if (sf_len == 0 || sf_len > dlc - 1)
			return r;
		sid = f.data[15:8];
		case (sid)
			SidSession: if (sf_len >= 2) begin
				diag_session = f.data[23:16];
				rp   = {40'd0, diag_session, RspSession, 8'h02};
				rlen = 3;
			end
			SidReadDid: if (sf_len >= 3) begin
				did = {f.data[23:16], f.data[31:24]};
				case (did)
					DidVin:    rec = "TESTVIN1234567890";
					DidHw:     rec = "HW_V1.0.0";
					DidSw:     rec = "SW_V2.3.1";
					DidVendor: rec = "VIRTUAL";
					default:   rec = "";
				endcase
				rsp[0]  = RspReadDid;
				rsp[1]  = did[15:8];
				rsp[2]  = did[7:0];
				rec_len = rec.len();
				for (int i = 0; i < rec_len; i++)
					rsp[3 + i] = rec[i];
				if (did == DidCustom) begin
					rsp[3]  = 8'h12;
					rsp[4]  = 8'h34;
					rsp[5]  = 8'h56;
					rsp[6]  = 8'h78;
					rec_len = 4;
				end else if (rec_len == 0) begin
					rsp[3]  = 8'h00;
					rsp[4]  = 8'h00;
					rec_len = 2;
				end
				total = rec_len + 3;
				if (total <= 7) begin
					rp[7:0] = 8'(total);
					for (int i = 0; i < total; i++)
						rp[8 * (i + 1) +: 8] = rsp[i];
					rlen = total + 1;
				end else begin
					rp[7:0]  = 8'h10 | 8'((total >> 8) & 15);
					rp[15:8] = 8'(total);
					for (int i = 0; i < 6; i++)
						rp[8 * (i + 2) +: 8] = rsp[i];
					rlen = 8;
				end
			end
			SidWriteDid: if (sf_len >= 3) begin
				rp   = {32'd0, f.data[31:24], f.data[23:16], RspWriteDid, 8'h03};
				rlen = 4;
			end
			SidRoutine: if (sf_len >= 4) begin
				rp   = {24'd0, f.data[39:16], RspRoutine, 8'h04};
				rlen = 5;
			end
			SidTesterPres: begin
				rp   = {48'd0, RspTesterPres, 8'h01};
				rlen = 2;
			end
			SidEcuReset: begin
				rp   = {48'd0, RspEcuReset, 8'h01};
				rlen = 2;
			end
			default: begin
				rp   = {32'd0, NrcNotSupp, sid, RspNegative, 8'h03};
				rlen = 4;
			end
		endcase
		if (rlen != 0) begin
			r.responded = 1'b1;
			r.id        = resp_id_q;
			r.ext       = f.ext;
			r.len       = DlcW'(rlen);
			r.data      = rp;
		end
		return r;
	endfunction

	function automatic void compare_field(input string name, input logic [63:0] want,
		input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin : reply_check
		reply_t want;
		if (arst_n && reply_valid && !reply_stall) begin
			if (expected_replies.size() == 0) begin
				$error("reply item with no frame outstanding");
				fail_count++;
			end else begin
				want = expected_replies.pop_front();
				compare_field("accepted", 64'(want.accepted), 64'(accepted));
				compare_field("responded", 64'(want.responded), 64'(responded));
				compare_field("reply_id", 64'(want.id), 64'(reply_id));
				compare_field("reply_extended", 64'(want.ext), 64'(reply_extended));
				compare_field("reply_length", 64'(want.len), 64'(reply_length));
				compare_field("reply_payload", want.data, reply_payload);
			end
		end
	end

	// reply side back-pressure: bursts of stall separated by calm stretches
	always @(posedge clk) begin
		if (stall_left > 0)
			stall_left--;
		else if (stall_calm > 0)
			stall_calm--;
		else if (idle_en) begin
			if ($urandom_range(0, 2) == 0)
				stall_left = $urandom_range(1, 17);
			else
				stall_calm = $urandom_range(0, 40);
		end
		reply_stall <= idle_en && stall_left > 0;
	end

	function automatic bit want_gap();
		if (!idle_en)
			return 1'b0;
		if (frame_calm > 0) begin
			frame_calm--;
			return 1'b0;
		end
		if ($urandom_range(0, 15) == 0) begin
			frame_calm = $urandom_range(10, 50);
			return 1'b0;
		end
		return $urandom_range(0, 3) == 0;
	endfunction

	task automatic queue_reply(input reply_t r);
		expected_replies = {expected_replies, r};
	endtask

	task automatic send_frame(input frame_t f);
		if (want_gap()) begin
			frame_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		frame_valid    <= 1'b1;
		frame_id       <= f.id;
		frame_extended <= f.ext;
		frame_length   <= f.len;
		frame_payload  <= f.data;
		@(posedge clk);
		while (frame_stall)
			@(posedge clk);
		queue_reply(predict_reply(f));
	endtask

	task automatic settle();
		frame_valid <= 1'b0;
		while (expected_replies.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [IdW-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			CfgAdapterOpen: open_q    = value[0];
			CfgEcuEnable:   enable_q  = value[0];
			CfgRequestId:   req_id_q  = value;
			CfgResponseId:  resp_id_q = value;
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic frame_t sf_frame(input logic [7:0] pci, input logic [7:0] sid,
		input logic [23:0] args, input logic [3:0] dlc, input logic ext);
		frame_t f;
		f.id   = req_id_q;
		f.ext  = ext;
		f.len  = dlc;
		f.data = {24'd0, args, sid, pci};
		return f;
	endfunction

	function automatic frame_t random_request();
		frame_t      f;
		int unsigned pick;
		int unsigned min_len;
		int unsigned sf_len;
		int unsigned dlc;
		logic [4:0]  bitpos;
		logic [7:0]  sid;
		logic [15:0] did;
		pick   = $urandom_range(0, 99);
		f.id   = req_id_q;
		f.ext  = 1'($urandom_range(0, 1));
		f.data = {$urandom, $urandom};
		if (pick >= 95) begin
			f.id  = IdW'($urandom);
			f.len = 4'($urandom_range(0, 15));
			return f;
		end
		case ($urandom_range(0, 6))
			0: begin sid = SidSession;    min_len = 2; end
			1: begin sid = SidReadDid;    min_len = 3; end
			2: begin sid = SidWriteDid;   min_len = 3; end
			3: begin sid = SidRoutine;    min_len = 4; end
			4: begin sid = SidTesterPres; min_len = 1; end
			5: begin sid = SidEcuReset;   min_len = 1; end
			default: begin sid = 8'($urandom); min_len = 1; end
		endcase
		sf_len = $urandom_range(min_len, 7);
		dlc    = $urandom_range(sf_len + 1, 8);
		if ($urandom_range(0, 9) == 0)
			dlc = $urandom_range(9, 15);
		f.len        = 4'(dlc);
		f.data[7:0]  = {4'h0, 4'(sf_len)};
		f.data[15:8] = sid;
		if (sid == SidReadDid && $urandom_range(0, 3) != 0) begin
			case ($urandom_range(0, 4))
				0:       did = DidVin;
				1:       did = DidHw;
				2:       did = DidSw;
				3:       did = DidVendor;
				default: did = DidCustom;
			endcase
			f.data[23:16] = did[15:8];
			f.data[31:24] = did[7:0];
		end
		if (pick >= 75 && pick < 83) begin
			bitpos       = 5'($urandom_range(0, IdW - 1));
			f.id[bitpos] = ~f.id[bitpos];
		end else if (pick >= 83 && pick < 90)
			f.data[7:0] = 8'($urandom);
		else if (pick >= 90)
			f.len = 4'($urandom_range(0, 15));
		return f;
	endfunction

	function automatic logic [IdW-1:0] random_id();
		case ($urandom_range(0, 3))
			0:       return '0;
			1:       return '1;
			default: return IdW'($urandom);
		endcase
	endfunction

	task automatic test_reset_defaults();
		// adapter is closed out of reset
		send_frame(sf_frame(8'h01, SidTesterPres, '0, 4'd8, 1'b0));
		send_frame('1);
		settle();
		write_reg(CfgAdapterOpen, IdW'(1));
		send_frame(sf_frame(8'h01, SidTesterPres, '0, 4'd2, 1'b0));
	endtask

	task automatic test_services();
		send_frame(sf_frame(8'h02, SidSession, 24'h000003, 4'd3, 1'b0));
		send_frame(sf_frame(8'h01, SidEcuReset, '0, 4'd8, 1'b0));
		send_frame(sf_frame(8'h03, SidReadDid, {8'h00, DidVin[7:0], DidVin[15:8]}, 4'd4, 1'b0));
		send_frame(sf_frame(8'h03, SidReadDid, {8'h00, DidHw[7:0], DidHw[15:8]}, 4'd8, 1'b1));
		send_frame(sf_frame(8'h03, SidReadDid, {8'h00, DidSw[7:0], DidSw[15:8]}, 4'd8, 1'b0));
		send_frame(sf_frame(8'h03, SidReadDid, {8'h00, DidVendor[7:0], DidVendor[15:8]},
			4'd8, 1'b0));
		send_frame(sf_frame(8'h03, SidReadDid, {8'h00, DidCustom[7:0], DidCustom[15:8]},
			4'd8, 1'b0));
		send_frame(sf_frame(8'h03, SidReadDid, 24'h0000FF, 4'd8, 1'b0));
		send_frame(sf_frame(8'h05, SidWriteDid, 24'hAA90F1, 4'd8, 1'b0));
		send_frame(sf_frame(8'h04, SidRoutine, 24'h00FF01, 4'd5, 1'b0));
		send_frame(sf_frame(8'h02, 8'h27, 24'h000001, 4'd8, 1'b1));
	endtask

	task automatic test_malformed();
		frame_t f;
		send_frame(sf_frame(8'h01, SidTesterPres, '0, 4'd0, 1'b0));   // empty frame
		send_frame(sf_frame(8'h21, SidTesterPres, '0, 4'd8, 1'b0));   // consecutive frame
		send_frame(sf_frame(8'h00, SidTesterPres, '0, 4'd8, 1'b0));   // zero SF length
		send_frame(sf_frame(8'h05, SidTesterPres, '0, 4'd5, 1'b0));   // SF length past DLC
		send_frame(sf_frame(8'h07, SidTesterPres, '0, 4'd15, 1'b1));  // DLC clamps to 8
		send_frame(sf_frame(8'h01, SidSession, 24'h000004, 4'd8, 1'b0));
		send_frame(sf_frame(8'h02, SidReadDid, 24'h0090F1, 4'd8, 1'b0));
		send_frame(sf_frame(8'h03, SidRoutine, 24'h000201, 4'd8, 1'b0));
		f    = sf_frame(8'h01, SidTesterPres, '0, 4'd8, 1'b0);
		f.id = req_id_q + IdW'(1);
		send_frame(f);
		f    = '1;
		f.id = req_id_q;
		send_frame(f);
	endtask

	task automatic test_ecu_disable();
		settle();
		write_reg(CfgEcuEnable, IdW'(0));
		send_frame(sf_frame(8'h01, SidTesterPres, '0, 4'd8, 1'b0));
		send_frame(sf_frame(8'h02, SidSession, 24'h000002, 4'd8, 1'b0));
		settle();
		write_reg(CfgEcuEnable, IdW'(1));
	endtask

	task automatic test_id_extremes();
		settle();
		write_reg(CfgRequestId, '0);
		write_reg(CfgResponseId, '1);
		send_frame(sf_frame(8'h02, SidSession, 24'h000081, 4'd8, 1'b1));
		send_frame(sf_frame(8'h03, SidReadDid, {8'h00, DidVin[7:0], DidVin[15:8]}, 4'd8, 1'b0));
		settle();
		write_reg(CfgRequestId, '1);
		write_reg(CfgResponseId, '0);
		send_frame(sf_frame(8'h01, SidEcuReset, '0, 4'd8, 1'b1));
		send_frame(sf_frame(8'h02, 8'hFF, 24'h0000FF, 4'd3, 1'b0));
	endtask

	task automatic test_random_phases();
		for (int phase = 0; phase < 5; phase++) begin
			settle();
			write_reg(CfgAdapterOpen, IdW'($urandom_range(0, 5) != 0));
			write_reg(CfgEcuEnable, IdW'($urandom_range(0, 5) != 0));
			write_reg(CfgRequestId, random_id());
			write_reg(CfgResponseId, random_id());
			repeat (110) send_frame(random_request());
		end
	endtask

	task automatic test_final_stretch();
		idle_en = 1'b0;
		settle();
		write_reg(CfgAdapterOpen, IdW'(1));
		write_reg(CfgEcuEnable, IdW'(1));
		write_reg(CfgRequestId, RequestIdRst);
		write_reg(CfgResponseId, ResponseIdRst);
		repeat (50) send_frame(random_request());
	endtask

	initial begin : main
		int guard;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_services();
		test_malformed();
		test_ecu_disable();
		test_id_extremes();
		test_random_phases();
		test_final_stretch();
		frame_valid <= 1'b0;
		guard = 0;
		while (expected_replies.size() != 0 && guard < 5000) begin
			@(posedge clk);
			guard++;
		end
		repeat (10) @(posedge clk);
		if (expected_replies.size() != 0) begin
			$error("%0d reply items never arrived", expected_replies.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
